### rtl/jfhp_pkg.sv
// Package with the shared types and constants of the JPEG frame header parser.
`default_nettype none
package jfhp_pkg;

    localparam int MAX_COMPONENTS = 4;
    localparam int DIV_W          = 18;
    localparam int DEN_W          = 6;
    localparam int CNT_W          = $clog2(DIV_W + 1);

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_LENGTH    = 4'd1,
        ST_PRECISION = 4'd2,
        ST_HEIGHT    = 4'd3,
        ST_WIDTH     = 4'd4,
        ST_COUNT     = 4'd5,
        ST_H         = 4'd6,
        ST_V         = 4'd7,
        ST_TABLE     = 4'd8,
        ST_SIZE      = 4'd9,
        ST_PROG      = 4'd10
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_LEN_LO, PH_PREC, PH_H_HI, PH_H_LO, PH_W_HI, PH_W_LO,
        PH_COUNT, PH_CID, PH_SAMP, PH_TQ
    } phase_t;

    typedef enum logic [3:0] {
        B_IDLE, B_MAX, B_MUL, B_SIZE, B_ERR_OUT, B_DX_GO, B_DX_WAIT,
        B_DY_GO, B_DY_WAIT, B_COMP_OUT, B_MX_GO, B_MX_WAIT, B_MY_GO,
        B_MY_WAIT, B_FRAME_OUT
    } back_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       segment_start;
        logic       progressive_frame;
    } in_word_t;

    typedef struct packed {
        logic        last;
        logic [3:0]  status;
        logic [1:0]  comp_index;
        logic [7:0]  comp_id;
        logic [2:0]  h_factor;
        logic [2:0]  v_factor;
        logic [1:0]  quant_table;
        logic [15:0] size_x;
        logic [15:0] size_y;
        logic [13:0] mcus_x;
        logic [13:0] mcus_y;
        logic [1:0]  rgb_ids;
    } out_word_t;

    // One finished segment handed from the front to the back.
    typedef struct packed {
        logic                            is_err;
        logic [3:0]                      status;
        logic                            load;
        logic                            prog;
        logic [15:0]                     x;
        logic [15:0]                     y;
        logic [2:0]                      count;
        logic [1:0]                      rgb;
        logic [MAX_COMPONENTS-1:0][7:0]  ids;
        logic [MAX_COMPONENTS-1:0][5:0]  samp;
        logic [MAX_COMPONENTS-1:0][1:0]  tq;
    } job_t;

    // Queue status seen by the back end.
    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage
`default_nettype wire

### rtl/jfhp_queue.sv
// Two-entry queue of segment jobs between the parser front and the back end.
`default_nettype none
module jfhp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire jfhp_pkg::job_t push_job,
    input  wire logic           pop,
    output jfhp_pkg::job_t      head_job,
    output jfhp_pkg::q_stat_t   stat
);
    import jfhp_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    // Pointer and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    assign head_job   = mem_reg[rd_ptr_reg];
    assign stat.valid = (cnt_reg != 2'd0);
    assign stat.full  = (cnt_reg == 2'd2);

endmodule
`default_nettype wire

### rtl/jfhp_front.sv
// Byte parser that checks the frame header fields and queues finished segments.
`default_nettype none
module jfhp_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load_mode,
    input  wire logic               in_fire,
    input  wire jfhp_pkg::in_word_t in_word,
    output logic                    push,
    output jfhp_pkg::job_t          push_job
);
    import jfhp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] len_reg, height_reg, width_reg;
    logic [2:0]  count_reg;
    logic [1:0]  cursor_reg;
    logic [1:0]  rgb_reg;
    logic        prog_reg;
    logic [MAX_COMPONENTS-1:0][7:0] ids_reg;
    logic [MAX_COMPONENTS-1:0][5:0] samp_reg;
    logic [MAX_COMPONENTS-1:0][1:0] tq_reg;

    logic [7:0]  b;
    logic        fail, finish;
    status_t     fstatus;
    logic [15:0] len_full, h_full, w_full;
    logic [3:0]  hn, vn;
    logic        rgb_hit;
    logic [MAX_COMPONENTS-1:0][1:0] tq_new;

    assign b        = in_word.data_byte;
    assign len_full = {len_reg[15:8], b};
    assign h_full   = {height_reg[15:8], b};
    assign w_full   = {width_reg[15:8], b};
    assign hn       = b[7:4];
    assign vn       = b[3:0];

    // Field checks for the byte at hand.
    always_comb
    begin
        fail    = 1'b0;
        finish  = 1'b0;
        fstatus = ST_OK;
        if (in_fire && !in_word.segment_start)
        begin
            case (phase_reg)
                PH_LEN_LO:
                    if (len_full < 16'd11)
                    begin
                        fail = 1'b1; fstatus = ST_LENGTH;
                    end
                PH_PREC:
                    if (b != 8'd8)
                    begin
                        fail = 1'b1; fstatus = ST_PRECISION;
                    end
                PH_H_LO:
                    if (h_full == 16'd0)
                    begin
                        fail = 1'b1; fstatus = ST_HEIGHT;
                    end
                PH_W_LO:
                    if (w_full == 16'd0)
                    begin
                        fail = 1'b1; fstatus = ST_WIDTH;
                    end
                PH_COUNT:
                    if (!(b inside {8'd1, 8'd3, 8'd4}))
                    begin
                        fail = 1'b1; fstatus = ST_COUNT;
                    end
                    else if (len_reg != 16'd8 + 16'd3 * {8'd0, b})
                    begin
                        fail = 1'b1; fstatus = ST_LENGTH;
                    end
                PH_SAMP:
                    if (hn == 4'd0 || hn > 4'd4)
                    begin
                        fail = 1'b1; fstatus = ST_H;
                    end
                    else if (vn == 4'd0 || vn > 4'd4)
                    begin
                        fail = 1'b1; fstatus = ST_V;
                    end
                PH_TQ:
                    if (b > 8'd3)
                    begin
                        fail = 1'b1; fstatus = ST_TABLE;
                    end
                    else if ({1'b0, cursor_reg} + 3'd1 >= count_reg)
                        finish = 1'b1;
                default:
                    fail = 1'b0;
            endcase
        end
    end

    // Next byte phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (in_fire)
        begin
            if (in_word.segment_start)
                phase_next = PH_LEN_LO;
            else if (fail || finish)
                phase_next = PH_IDLE;
            else
            begin
                case (phase_reg)
                    PH_LEN_LO: phase_next = PH_PREC;
                    PH_PREC:   phase_next = PH_H_HI;
                    PH_H_HI:   phase_next = PH_H_LO;
                    PH_H_LO:   phase_next = PH_W_HI;
                    PH_W_HI:   phase_next = PH_W_LO;
                    PH_W_LO:   phase_next = PH_COUNT;
                    PH_COUNT:  phase_next = PH_CID;
                    PH_CID:    phase_next = PH_SAMP;
                    PH_SAMP:   phase_next = PH_TQ;
                    PH_TQ:     phase_next = PH_CID;
                    default:   phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else
            phase_reg <= phase_next;
    end

    // An id matches when three components carry R, G, B in order.
    always_comb
    begin
        case (cursor_reg)
            2'd0:    rgb_hit = (b == 8'h52);
            2'd1:    rgb_hit = (b == 8'h47);
            2'd2:    rgb_hit = (b == 8'h42);
            default: rgb_hit = 1'b0;
        endcase
        rgb_hit = rgb_hit && (count_reg == 3'd3);
    end

    // Header field registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= 16'd0;
            height_reg <= 16'd0;
            width_reg  <= 16'd0;
            count_reg  <= 3'd0;
            cursor_reg <= 2'd0;
            rgb_reg    <= 2'd0;
            prog_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            if (in_word.segment_start)
            begin
                prog_reg   <= in_word.progressive_frame;
                len_reg    <= {b, 8'd0};
                rgb_reg    <= 2'd0;
                count_reg  <= 3'd0;
                cursor_reg <= 2'd0;
                height_reg <= 16'd0;
                width_reg  <= 16'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_LEN_LO: len_reg <= len_full;
                    PH_H_HI:   height_reg <= {b, 8'd0};
                    PH_H_LO:   height_reg <= h_full;
                    PH_W_HI:   width_reg <= {b, 8'd0};
                    PH_W_LO:   width_reg <= w_full;
                    PH_COUNT:
                        if (b inside {8'd1, 8'd3, 8'd4})
                        begin
                            count_reg  <= b[2:0];
                            cursor_reg <= 2'd0;
                        end
                    PH_CID:
                        if (rgb_hit)
                            rgb_reg <= rgb_reg + 2'd1;
                    PH_TQ:
                        if (!fail && !finish)
                            cursor_reg <= cursor_reg + 2'd1;
                    default:
                        cursor_reg <= cursor_reg;
                endcase
            end
        end
    end

    // Per-component stores, written as their bytes arrive.
    always_ff @(posedge clk)
    begin
        if (in_fire && !in_word.segment_start)
        begin
            if (phase_reg == PH_CID)
                ids_reg[cursor_reg] <= b;
            if (phase_reg == PH_SAMP && !fail)
                samp_reg[cursor_reg] <= {hn[2:0], vn[2:0]};
            if (phase_reg == PH_TQ && !fail)
                tq_reg[cursor_reg] <= b[1:0];
        end
    end

    // Job built from the stores, with the closing table byte folded in.
    always_comb
    begin
        tq_new             = tq_reg;
        tq_new[cursor_reg] = b[1:0];
        push               = fail || finish;
        push_job.is_err    = fail;
        push_job.status    = fstatus;
        push_job.load      = load_mode;
        push_job.prog      = prog_reg;
        push_job.x         = width_reg;
        push_job.y         = height_reg;
        push_job.count     = count_reg;
        push_job.rgb       = rgb_reg;
        push_job.ids       = ids_reg;
        push_job.samp      = samp_reg;
        push_job.tq        = tq_new;
    end

endmodule
`default_nettype wire

### rtl/jfhp_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module jfhp_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [jfhp_pkg::DIV_W-1:0] numer,
    input  wire logic [jfhp_pkg::DEN_W-1:0] denom,
    output logic                            busy,
    output logic                            done,
    output logic [jfhp_pkg::DIV_W-1:0]      quot
);
    import jfhp_pkg::*;

    logic [DIV_W-1:0] work_reg;
    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial;
    logic             qbit;

    // One shift and trial subtract per step.
    assign trial = {rem_reg, work_reg[DIV_W-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= numer;
            den_reg  <= denom;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= qbit ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            work_reg <= {work_reg[DIV_W-2:0], qbit};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = work_reg;

endmodule
`default_nettype wire

### rtl/jfhp_back.sv
// Back end that checks the frame size and produces the result words of a segment.
`default_nettype none
module jfhp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire jfhp_pkg::job_t      head_job,
    input  wire jfhp_pkg::q_stat_t   q_stat,
    output logic                     pop,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output jfhp_pkg::out_word_t      result_word
);
    import jfhp_pkg::*;

    back_state_t state_reg, state_next;
    job_t        job_reg;
    logic [2:0]  hmax_reg, vmax_reg, hmax_c, vmax_c;
    logic [31:0] prod_reg;
    logic [34:0] total;
    logic [1:0]  idx_reg;
    logic [15:0] sx_reg, sy_reg;
    logic [13:0] mx_reg, my_reg;
    logic [3:0]  err_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg, out_word_c;
    logic        out_free, load_out, size_bad, comp_last;
    logic [2:0]  h_i, v_i;

    logic                div_start, div_busy, div_done;
    logic [DIV_W-1:0]    div_numer, div_quot;
    logic [DEN_W-1:0]    div_denom;

    jfhp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_free  = !out_valid_reg || result_ready;
    assign h_i       = job_reg.samp[idx_reg][5:3];
    assign v_i       = job_reg.samp[idx_reg][2:0];
    assign total     = {3'd0, prod_reg} * {32'd0, job_reg.count};
    assign size_bad  = (total > 35'h7FFF_FFFF);
    assign comp_last = ({1'b0, idx_reg} + 3'd1 >= job_reg.count);

    // Maximum sampling factors over the components present.
    always_comb
    begin
        hmax_c = 3'd1;
        vmax_c = 3'd1;
        for (int i = 0; i < MAX_COMPONENTS; i++)
        begin
            if (i < int'(job_reg.count))
            begin
                if (job_reg.samp[i][5:3] > hmax_c)
                    hmax_c = job_reg.samp[i][5:3];
                if (job_reg.samp[i][2:0] > vmax_c)
                    vmax_c = job_reg.samp[i][2:0];
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (q_stat.valid)
                    state_next = head_job.is_err ? B_ERR_OUT : B_MAX;
            B_MAX:
                state_next = job_reg.load ? B_MUL : B_FRAME_OUT;
            B_MUL:
                state_next = B_SIZE;
            B_SIZE:
                state_next = (size_bad || job_reg.prog) ? B_ERR_OUT : B_DX_GO;
            B_ERR_OUT:
                if (out_free)
                    state_next = B_IDLE;
            B_DX_GO:   state_next = B_DX_WAIT;
            B_DX_WAIT: if (div_done) state_next = B_DY_GO;
            B_DY_GO:   state_next = B_DY_WAIT;
            B_DY_WAIT: if (div_done) state_next = B_COMP_OUT;
            B_COMP_OUT:
                if (out_free)
                    state_next = comp_last ? B_MX_GO : B_DX_GO;
            B_MX_GO:   state_next = B_MX_WAIT;
            B_MX_WAIT: if (div_done) state_next = B_MY_GO;
            B_MY_GO:   state_next = B_MY_WAIT;
            B_MY_WAIT: if (div_done) state_next = B_FRAME_OUT;
            B_FRAME_OUT:
                if (out_free)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    // Controls and the result word of the current state.
    always_comb
    begin
        pop        = 1'b0;
        div_start  = 1'b0;
        div_numer  = '0;
        div_denom  = DEN_W'(1);
        load_out   = 1'b0;
        out_word_c = '0;
        case (state_reg)
            B_IDLE:
                pop = q_stat.valid;
            B_DX_GO:
            begin
                div_start = 1'b1;
                div_numer = DIV_W'(job_reg.x) * DIV_W'(h_i) + DIV_W'(hmax_reg - 3'd1);
                div_denom = DEN_W'(hmax_reg);
            end
            B_DY_GO:
            begin
                div_start = 1'b1;
                div_numer = DIV_W'(job_reg.y) * DIV_W'(v_i) + DIV_W'(vmax_reg - 3'd1);
                div_denom = DEN_W'(vmax_reg);
            end
            B_MX_GO:
            begin
                div_start = 1'b1;
                div_numer = DIV_W'(job_reg.x) + DIV_W'({hmax_reg, 3'd0}) - DIV_W'(1);
                div_denom = {hmax_reg, 3'd0};
            end
            B_MY_GO:
            begin
                div_start = 1'b1;
                div_numer = DIV_W'(job_reg.y) + DIV_W'({vmax_reg, 3'd0}) - DIV_W'(1);
                div_denom = {vmax_reg, 3'd0};
            end
            B_ERR_OUT:
            begin
                load_out          = out_free;
                out_word_c.last   = 1'b1;
                out_word_c.status = err_reg;
            end
            B_COMP_OUT:
            begin
                load_out               = out_free;
                out_word_c.comp_index  = idx_reg;
                out_word_c.comp_id     = job_reg.ids[idx_reg];
                out_word_c.h_factor    = h_i;
                out_word_c.v_factor    = v_i;
                out_word_c.quant_table = job_reg.tq[idx_reg];
                out_word_c.size_x      = sx_reg;
                out_word_c.size_y      = sy_reg;
            end
            B_FRAME_OUT:
            begin
                load_out            = out_free;
                out_word_c.last     = 1'b1;
                out_word_c.status   = ST_OK;
                out_word_c.h_factor = hmax_reg;
                out_word_c.v_factor = vmax_reg;
                out_word_c.size_x   = job_reg.x;
                out_word_c.size_y   = job_reg.y;
                out_word_c.mcus_x   = mx_reg;
                out_word_c.mcus_y   = my_reg;
                out_word_c.rgb_ids  = job_reg.rgb;
            end
            default:
                pop = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == B_IDLE)
                idx_reg <= 2'd0;
            else if (state_reg == B_COMP_OUT && out_free)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head_job;
            err_reg <= head_job.status;
        end
        if (state_reg == B_MAX)
        begin
            hmax_reg <= hmax_c;
            vmax_reg <= vmax_c;
            mx_reg   <= 14'd0;
            my_reg   <= 14'd0;
        end
        if (state_reg == B_MUL)
            prod_reg <= {16'd0, job_reg.x} * {16'd0, job_reg.y};
        if (state_reg == B_SIZE)
            err_reg <= size_bad ? 4'(ST_SIZE) : 4'(ST_PROG);
        if (div_done)
        begin
            case (state_reg)
                B_DX_WAIT: sx_reg <= div_quot[15:0];
                B_DY_WAIT: sy_reg <= div_quot[15:0];
                B_MX_WAIT: mx_reg <= div_quot[13:0];
                B_MY_WAIT: my_reg <= div_quot[13:0];
                default:   sx_reg <= sx_reg;
            endcase
        end
        if (load_out)
            out_word_reg <= out_word_c;
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    // The divider is only started when it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // A frame result always closes the segment.
    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FRAME_OUT && out_free) |=> (result_valid && result_word.last))
        else $error("frame result without last");

    // The horizontal size division uses a valid maximum factor.
    a_hmax_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DX_GO) |-> (hmax_reg != 3'd0 && hmax_reg <= 3'd4))
        else $error("maximum H out of range");

endmodule
`default_nettype wire

### rtl/jpeg_frame_header_parser_top.sv
// Top level of the JPEG start-of-frame header parser.
//
// Input channel: byte_valid/byte_ready/byte_word carries one segment byte per
// word, starting with the high length byte flagged by segment_start. A word is
// taken whenever the two-entry job queue has room, so bytes flow at one per
// cycle, until the queue fills, while the back end works on earlier segments.
// Result channel: result_valid/result_ready/result_word, held in an output
// register. A front error gives one error word; a size or progressive error
// gives one after the B_MAX, B_MUL and B_SIZE states. Header-only mode gives
// one frame word. Load mode gives one word per component and a frame word.
// Each division has a start, 18 quotient bits and a done; a component needs
// two of them plus an output state and the MCU counts two more, all on the
// one-bit-per-cycle divider shared by all sizes.
// Configuration: cfg_we writes cfg_data into load_mode (reset value 1).
// Reset clears the parser phase, the queue and the output register.
// When the receiver stalls, the back end holds its word and waits; the front
// keeps taking bytes until the queue fills, then drops byte_ready.
`default_nettype none
module jpeg_frame_header_parser_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_data,
    input  wire logic                byte_valid,
    output logic                     byte_ready,
    input  wire jfhp_pkg::in_word_t  byte_word,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output jfhp_pkg::out_word_t      result_word
);
    import jfhp_pkg::*;

    logic    load_mode_reg;
    logic    in_fire, push, pop;
    job_t    push_job, head_job;
    q_stat_t q_stat;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_mode_reg <= 1'b1;
        else if (cfg_we)
            load_mode_reg <= cfg_data;
    end

    assign byte_ready = !q_stat.full;
    assign in_fire    = byte_valid && byte_ready;

    jfhp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_mode (load_mode_reg),
        .in_fire   (in_fire),
        .in_word   (byte_word),
        .push      (push),
        .push_job  (push_job)
    );

    jfhp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    jfhp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (head_job),
        .q_stat       (q_stat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

endmodule
`default_nettype wire

### bench/jpeg_frame_header_parser_top_tb.sv
// Self-checking testbench for the JPEG start-of-frame header parser.
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: predicts the parser's result words and checks the words it emits.
class sof_scoreboard;
    bit          load_mode;
    jfhp_pkg::phase_t phase;
    bit [15:0]   seg_len;
    bit [15:0]   img_h;
    bit [15:0]   img_w;
    bit [2:0]    n_comp;
    bit [1:0]    cursor;
    bit [7:0]    ids [4];
    bit [2:0]    hs [4];
    bit [2:0]    vs [4];
    bit [1:0]    tqs [4];
    bit [1:0]    rgb_cnt;
    bit          prog;
    jfhp_pkg::out_word_t pending[$];
    int          errors;
    int          words_seen;
    int          frames_seen;
    int          fail_seen;

    function new();
        load_mode = 1'b1;
        phase = jfhp_pkg::PH_IDLE;
    endfunction

    function void push_word(bit lst, jfhp_pkg::status_t st, bit [1:0] idx, bit [7:0] id,
                            bit [2:0] h, bit [2:0] v, bit [1:0] tq, bit [15:0] sx,
                            bit [15:0] sy, bit [13:0] mx, bit [13:0] my, bit [1:0] rgb);
        jfhp_pkg::out_word_t w;
        w.last = lst; w.status = st; w.comp_index = idx; w.comp_id = id;
        w.h_factor = h; w.v_factor = v; w.quant_table = tq;
        w.size_x = sx; w.size_y = sy; w.mcus_x = mx; w.mcus_y = my; w.rgb_ids = rgb;
        pending.push_back(w);
    endfunction

    function void abort_segment(jfhp_pkg::status_t st);
        phase = jfhp_pkg::PH_IDLE;
        push_word(1'b1, st, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    endfunction

    // Closing byte: compute component sizes and MCU counts.
    function void close_segment();
        int unsigned hmax, vmax, sx, sy;
        longint unsigned area;
        hmax = 1; vmax = 1;
        phase = jfhp_pkg::PH_IDLE;
        for (int i = 0; i < n_comp; i++) begin
            if (hs[i] > hmax) hmax = hs[i];
            if (vs[i] > vmax) vmax = vs[i];
        end
        if (!load_mode) begin
            push_word(1'b1, jfhp_pkg::ST_OK, 0, 0, hmax, vmax, 0, img_w, img_h, 0, 0,
                      rgb_cnt);
            return;
        end
        area = longint'(img_w) * longint'(img_h) * longint'(n_comp);
        if (area > 64'h7FFF_FFFF) begin
            abort_segment(jfhp_pkg::ST_SIZE);
            return;
        end
        if (prog) begin
            abort_segment(jfhp_pkg::ST_PROG);
            return;
        end
        for (int i = 0; i < n_comp; i++) begin
            sx = (img_w * hs[i] + hmax - 1) / hmax;
            sy = (img_h * vs[i] + vmax - 1) / vmax;
            push_word(1'b0, jfhp_pkg::ST_OK, i, ids[i], hs[i], vs[i], tqs[i], sx, sy,
                      0, 0, 0);
        end
        push_word(1'b1, jfhp_pkg::ST_OK, 0, 0, hmax, vmax, 0, img_w, img_h,
                  (img_w + 8 * hmax - 1) / (8 * hmax), (img_h + 8 * vmax - 1) / (8 * vmax),
                  rgb_cnt);
    endfunction

    // Advance the parser state by one accepted input word.
    function void note_byte(jfhp_pkg::in_word_t iw);
        bit [7:0] b;
        bit [3:0] hh, vv;
        b = iw.data_byte;
        if (iw.segment_start) begin
            prog = iw.progressive_frame;
            seg_len = {b, 8'h00};
            rgb_cnt = 0; n_comp = 0; cursor = 0; img_h = 0; img_w = 0;
            phase = jfhp_pkg::PH_LEN_LO;
            return;
        end
        case (phase)
            jfhp_pkg::PH_LEN_LO: begin
                seg_len[7:0] = b;
                if (seg_len < 11) abort_segment(jfhp_pkg::ST_LENGTH);
                else phase = jfhp_pkg::PH_PREC;
            end
            jfhp_pkg::PH_PREC:
                if (b != 8) abort_segment(jfhp_pkg::ST_PRECISION);
                else phase = jfhp_pkg::PH_H_HI;
            jfhp_pkg::PH_H_HI: begin
                img_h = {b, 8'h00};
                phase = jfhp_pkg::PH_H_LO;
            end
            jfhp_pkg::PH_H_LO: begin
                img_h[7:0] = b;
                if (img_h == 0) abort_segment(jfhp_pkg::ST_HEIGHT);
                else phase = jfhp_pkg::PH_W_HI;
            end
            jfhp_pkg::PH_W_HI: begin
                img_w = {b, 8'h00};
                phase = jfhp_pkg::PH_W_LO;
            end
            jfhp_pkg::PH_W_LO: begin
                img_w[7:0] = b;
                if (img_w == 0) abort_segment(jfhp_pkg::ST_WIDTH);
                else phase = jfhp_pkg::PH_COUNT;
            end
            jfhp_pkg::PH_COUNT: begin
                if (b != 1 && b != 3 && b != 4) abort_segment(jfhp_pkg::ST_COUNT);
                else begin
                    n_comp = b[2:0];
                    if (seg_len != 8 + 3 * b) abort_segment(jfhp_pkg::ST_LENGTH);
                    else begin
                        cursor = 0;
                        phase = jfhp_pkg::PH_CID;
                    end
                end
            end
            jfhp_pkg::PH_CID: begin
                ids[cursor] = b;
                if (n_comp == 3 && ((cursor == 0 && b == 8'h52) ||
                    (cursor == 1 && b == 8'h47) || (cursor == 2 && b == 8'h42)))
                    rgb_cnt = rgb_cnt + 1;
                phase = jfhp_pkg::PH_SAMP;
            end
            jfhp_pkg::PH_SAMP: begin
                hh = b[7:4]; vv = b[3:0];
                if (hh == 0 || hh > 4) abort_segment(jfhp_pkg::ST_H);
                else if (vv == 0 || vv > 4) abort_segment(jfhp_pkg::ST_V);
                else begin
                    hs[cursor] = hh[2:0];
                    vs[cursor] = vv[2:0];
                    phase = jfhp_pkg::PH_TQ;
                end
            end
            jfhp_pkg::PH_TQ: begin
                if (b > 3) abort_segment(jfhp_pkg::ST_TABLE);
                else begin
                    tqs[cursor] = b[1:0];
                    if (cursor + 1 >= n_comp) close_segment();
                    else begin
                        cursor = cursor + 1;
                        phase = jfhp_pkg::PH_CID;
                    end
                end
            end
            default: phase = jfhp_pkg::PH_IDLE;
        endcase
    endfunction

    // Compare one emitted word against the oldest prediction.
    function void check_result(jfhp_pkg::out_word_t got);
        jfhp_pkg::out_word_t e;
        words_seen++;
        if (pending.size() == 0) begin
            $error("unexpected result word %h", got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e.last && e.status == jfhp_pkg::ST_OK) frames_seen++;
        if (e.status != jfhp_pkg::ST_OK) fail_seen++;
        if (got.last != e.last) begin
            $error("last: expected %0d, got %0d", e.last, got.last); errors++; end
        if (got.status != e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status); errors++; end
        if (got.comp_index != e.comp_index) begin
            $error("comp_index: expected %0d, got %0d", e.comp_index, got.comp_index);
            errors++; end
        if (got.comp_id != e.comp_id) begin
            $error("comp_id: expected %0d, got %0d", e.comp_id, got.comp_id); errors++; end
        if (got.h_factor != e.h_factor) begin
            $error("h_factor: expected %0d, got %0d", e.h_factor, got.h_factor);
            errors++; end
        if (got.v_factor != e.v_factor) begin
            $error("v_factor: expected %0d, got %0d", e.v_factor, got.v_factor);
            errors++; end
        if (got.quant_table != e.quant_table) begin
            $error("quant_table: expected %0d, got %0d", e.quant_table, got.quant_table);
            errors++; end
        if (got.size_x != e.size_x) begin
            $error("size_x: expected %0d, got %0d", e.size_x, got.size_x); errors++; end
        if (got.size_y != e.size_y) begin
            $error("size_y: expected %0d, got %0d", e.size_y, got.size_y); errors++; end
        if (got.mcus_x != e.mcus_x) begin
            $error("mcus_x: expected %0d, got %0d", e.mcus_x, got.mcus_x); errors++; end
        if (got.mcus_y != e.mcus_y) begin
            $error("mcus_y: expected %0d, got %0d", e.mcus_y, got.mcus_y); errors++; end
        if (got.rgb_ids != e.rgb_ids) begin
            $error("rgb_ids: expected %0d, got %0d", e.rgb_ids, got.rgb_ids); errors++; end
    endfunction
endclass

module jpeg_frame_header_parser_top_tb;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;
    logic byte_valid;
    logic byte_ready;
    jfhp_pkg::in_word_t byte_word;
    logic result_valid;
    logic result_ready;
    jfhp_pkg::out_word_t result_word;

    sof_scoreboard sb;
    int cycles;
    int bytes_sent;
    int burst_left;
    bit stall_on;

    jpeg_frame_header_parser_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .byte_valid(byte_valid), .byte_ready(byte_ready), .byte_word(byte_word),
        .result_valid(result_valid), .result_ready(result_ready),
        .result_word(result_word)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle counter guards against a hung run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL jpeg_frame_header_parser_top");
            $finish;
        end
    end

    // Receiver: stalls on its own pattern, checks each accepted word.
    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid && result_ready) sb.check_result(result_word);
            if ((cycles % 512) < 128) result_ready <= 1'b1;
            else if (stall_on) result_ready <= ($urandom_range(0, 3) != 0);
            else result_ready <= ($urandom_range(0, 1) == 1);
        end
    end

    // Send one word, with burst/gap pacing; valid stays up within a burst.
    task automatic send_word(bit [7:0] b, bit st, bit pr);
        if (burst_left == 0) begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        byte_valid <= 1'b1;
        byte_word <= '{data_byte: b, segment_start: st, progressive_frame: pr};
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        sb.note_byte('{data_byte: b, segment_start: st, progressive_frame: pr});
        bytes_sent++;
        burst_left--;
    endtask

    // Stop sending and wait until every predicted word has arrived.
    task automatic drain();
        byte_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(bit m);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.load_mode = m;
    endtask

    // Send a whole segment; the field values and the length are given by the caller.
    task automatic send_segment(bit pr, int lf, bit [7:0] prec, bit [15:0] h, bit [15:0] w,
                                bit [7:0] n, bit [7:0] cid[4], bit [7:0] samp[4],
                                bit [7:0] tq[4]);
        send_word(lf[15:8], 1'b1, pr);
        send_word(lf[7:0], 1'b0, $urandom_range(0, 1));
        send_word(prec, 1'b0, 1'b0);
        send_word(h[15:8], 1'b0, 1'b0);
        send_word(h[7:0], 1'b0, 1'b0);
        send_word(w[15:8], 1'b0, 1'b0);
        send_word(w[7:0], 1'b0, 1'b0);
        send_word(n, 1'b0, 1'b0);
        for (int i = 0; i < n && i < 4; i++) begin
            send_word(cid[i], 1'b0, 1'b0);
            send_word(samp[i], 1'b0, 1'b0);
            send_word(tq[i], 1'b0, 1'b0);
        end
    endtask

    // Random segment: mostly well formed, sometimes with a corrupted field.
    task automatic random_segment(bit allow_big);
        bit [7:0] cid[4], samp[4], tq[4];
        bit [7:0] n, prec;
        bit [15:0] h, w;
        int lf;
        int bad;
        int pick;
        pick = $urandom_range(0, 2);
        n = (pick == 0) ? 1 : (pick == 1) ? 3 : 4;
        if (allow_big && $urandom_range(0, 3) == 0) begin
            h = $urandom; w = $urandom;
        end else begin
            h = $urandom_range(1, 300); w = $urandom_range(1, 300);
        end
        if (h == 0) h = 1;
        if (w == 0) w = 1;
        prec = 8;
        for (int i = 0; i < 4; i++) begin
            cid[i] = ($urandom_range(0, 1) && n == 3) ? ((i == 0) ? 8'h52 : (i == 1) ? 8'h47
                     : 8'h42) : 8'($urandom);
            samp[i] = {4'($urandom_range(1, 4)), 4'($urandom_range(1, 4))};
            tq[i] = $urandom_range(0, 3);
        end
        lf = 8 + 3 * n;
        bad = $urandom_range(0, 9);
        case (bad)
            0: prec = $urandom;
            1: lf = $urandom_range(0, 40);
            2: n = $urandom_range(0, 7);
            3: samp[$urandom_range(0, n - 1)] = $urandom;
            4: tq[$urandom_range(0, n - 1)] = $urandom;
            5: h = ($urandom_range(0, 1)) ? 0 : h;
            6: w = ($urandom_range(0, 1)) ? 0 : w;
            default: ;
        endcase
        if (bad == 2 && (n == 1 || n == 3 || n == 4)) lf = 8 + 3 * n;
        send_segment($urandom_range(0, 7) == 0, lf, prec, h, w, n, cid, samp, tq);
    endtask

    initial begin
        bit [7:0] cid[4], samp[4], tq[4];
        sb = new();
        cycles = 0;
        bytes_sent = 0;
        burst_left = 0;
        stall_on = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        byte_valid = 1'b0;
        byte_word = '0;
        result_ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: stray bytes, each error, RGB ids, extremes, restart.
        cid = '{8'h52, 8'h47, 8'h42, 8'hFF};
        samp = '{8'h44, 8'h11, 8'h12, 8'h21};
        tq = '{8'd0, 8'd3, 8'd1, 8'd2};
        send_word(8'hAA, 1'b0, 1'b1);
        send_segment(1'b0, 17, 8, 16'h0001, 16'h0001, 3, cid, samp, tq);
        send_segment(1'b0, 10, 8, 1, 1, 1, cid, samp, tq);
        send_word(8'h55, 1'b0, 1'b0);
        send_segment(1'b0, 11, 7, 1, 1, 1, cid, samp, tq);
        send_segment(1'b0, 11, 8, 0, 1, 1, cid, samp, tq);
        drain();
        send_segment(1'b0, 11, 8, 1, 0, 1, cid, samp, tq);
        send_segment(1'b0, 11, 8, 1, 1, 2, cid, samp, tq);
        send_segment(1'b0, 11, 8, 1, 1, 3, cid, samp, tq);
        samp[0] = 8'h51;
        send_segment(1'b0, 11, 8, 5, 5, 1, cid, samp, tq);
        samp[0] = 8'h40;
        send_segment(1'b0, 11, 8, 5, 5, 1, cid, samp, tq);
        samp[0] = 8'h44; tq[0] = 8'hFF;
        send_segment(1'b0, 11, 8, 5, 5, 1, cid, samp, tq);
        tq[0] = 0;
        send_segment(1'b0, 20, 8, 16'hFFFF, 16'hFFFF, 4, cid, samp, tq);
        send_segment(1'b1, 17, 8, 100, 200, 3, cid, samp, tq);
        send_word(8'h00, 1'b1, 1'b0);
        send_segment(1'b0, 20, 8, 16'h7FFF, 16'h0FFF, 4, cid, samp, tq);
        write_mode(1'b0);
        send_segment(1'b1, 17, 8, 16'hFFFF, 16'hFFFF, 3, cid, samp, tq);

        // Random part over both mode settings, with receiver stall changes.
        for (int phase_no = 0; phase_no < 4; phase_no++) begin
            write_mode(phase_no[0]);
            stall_on = phase_no[1];
            for (int s = 0; s < 1; s++) begin
                random_segment(1'b1);
                if ($urandom_range(0, 5) == 0) send_word($urandom, 1'b0, $urandom);
            end
        end
        write_mode(1'b1);
        while (bytes_sent < 240) random_segment(1'b0);
        drain();

        $display("Covered %0d input words, %0d result words: %0d frames, %0d error ends.",
                 bytes_sent, sb.words_seen, sb.frames_seen, sb.fail_seen);
        if (sb.errors == 0)
            $display("PASS jpeg_frame_header_parser_top");
        else
            $display("FAIL jpeg_frame_header_parser_top");
        $finish;
    end
endmodule

`default_nettype wire
